// ===== rtl/core/thread_slot_round_robin_scheduler_unit_assert.svh =====
// Assertion macros for the thread slot scheduler top level.
// Needs a clock and an active-low reset name at each use; no other dependencies.
`ifndef THREAD_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_ASSERT_SVH
`define THREAD_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_ASSERT_SVH

// Check a property every cycle outside reset.
`define TSRR_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("tsrr: assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define TSRR_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("tsrr: assertion failed");

`endif

// ===== rtl/core/tsrr_pkg.sv =====
// Package for the thread slot scheduler: request codes, payload structs, queue control.
// No dependencies; imported by tsrr_ready_queue and the top level.
package tsrr_pkg;

	localparam int unsigned SLOTS_W = 5;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned TID_W = 4;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_YIELD  = 2'd1,
		REQ_FINISH = 2'd2,
		REQ_NONE   = 2'd3
	} tsrr_req_t;

	typedef struct packed {
		tsrr_req_t           req_type;
		logic [ADDR_W-1:0]   entry_addr;
	} tsrr_in_t;

	typedef struct packed {
		logic [TID_W-1:0]    thread_id;
		logic                create_failed;
		logic                fresh_start;
		logic [ADDR_W-1:0]   start_addr;
		logic [TID_W-1:0]    running_thread;
	} tsrr_out_t;

	typedef struct packed {
		logic rd_en;
		logic push;
		logic pop;
	} tsrr_q_ctl_t;

endpackage

// ===== rtl/core/tsrr_ready_queue.sv =====
// Ready queue of the thread slot scheduler: circular buffer in a synchronous memory.
// Depends on tsrr_pkg for the control struct.
module tsrr_ready_queue #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned DATA_W = 37
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsrr_pkg::tsrr_q_ctl_t      ctl,
	input  logic [DATA_W-1:0]          push_data,
	output logic [DATA_W-1:0]          head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import tsrr_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic              push_ok, pop_ok;

	// A pop on an empty queue is served by a push of the same cycle.
	assign push_ok = ctl.push && (count_q < CNT_W'(DEPTH));
	assign pop_ok  = ctl.pop && ((count_q != '0) || push_ok);
	assign count   = count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) tail_q <= ptr_inc(tail_q);
			if (pop_ok)  head_q <= ptr_inc(head_q);
			count_q <= count_q + CNT_W'(push_ok) - CNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) mem[tail_q] <= push_data;
		if (ctl.rd_en) head_data <= mem[head_q];
	end

endmodule

// ===== rtl/core/thread_slot_round_robin_scheduler_unit.sv =====
// Thread slot round-robin scheduler, top level.
// An accepted request is held and runs in ST_EXEC; the result register loads when
// it fires, which waits while the output holds an unaccepted result. No new request
// is taken until then; the queue head is fetched at accept, consumed at execution.
// Reset: slot occupancy, queue pointers and running thread clear (main runs),
// slots_in_use returns to 16; the queue memory is not cleared.
`include "thread_slot_round_robin_scheduler_unit_assert.svh"

module thread_slot_round_robin_scheduler_unit #(
	parameter int unsigned MAX_THREADS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsrr_pkg::SLOTS_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tsrr_pkg::tsrr_in_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tsrr_pkg::tsrr_out_t              out_data
);
	import tsrr_pkg::*;

	localparam int unsigned SLOT_W = $clog2(MAX_THREADS);
	localparam int unsigned CNT_W  = $clog2(MAX_THREADS + 1);
	// Only slots below slots_in_use (at most 31) can ever be created.
	localparam int unsigned SRCH_N = (MAX_THREADS < 32) ? MAX_THREADS : 32;
	// Queue entry: {fresh flag, entry address, slot number}.
	localparam int unsigned QD_W   = 1 + ADDR_W + SLOT_W;

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t                  state_q;
	logic                    out_valid_q;
	tsrr_out_t               out_data_q;
	tsrr_req_t               req_q;
	logic [ADDR_W-1:0]       entry_q;
	logic [SLOTS_W-1:0]      slots_q;
	logic [MAX_THREADS-1:0]  occ_q, occ_d;
	logic [SLOT_W-1:0]       cur_q, cur_d;

	tsrr_q_ctl_t             q_ctl;
	logic [QD_W-1:0]         q_push_data, q_head, pop_data;
	logic [CNT_W-1:0]        q_count;

	logic                    exec_fire, found, will_push, pop_ok, is_dispatch;
	logic [SLOT_W-1:0]       free_slot, pop_slot;
	tsrr_out_t               res;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// Lowest empty slot from 1 up within the configured slot count.
	always_comb begin
		found     = 1'b0;
		free_slot = '0;
		for (int i = SRCH_N - 1; i >= 1; i--) begin
			if (!occ_q[i] && (6'(i) < {1'b0, slots_q})) begin
				found     = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	// Execute one request: queue traffic, occupancy, running thread, result.
	always_comb begin
		q_ctl       = '0;
		q_ctl.rd_en = in_valid && in_ready;
		q_push_data = '0;
		will_push   = 1'b0;
		res         = '0;
		occ_d       = occ_q;
		cur_d       = cur_q;
		is_dispatch = 1'b0;
		unique case (req_q)
			REQ_CREATE: begin
				res.create_failed  = !found;
				res.thread_id      = found ? TID_W'(free_slot) : '0;
				res.running_thread = TID_W'(cur_q);
				if (found) begin
					occ_d[free_slot] = 1'b1;
					will_push        = 1'b1;
					q_push_data      = {1'b1, entry_q, free_slot};
				end
			end
			REQ_YIELD: begin
				is_dispatch = 1'b1;
				if (cur_q != '0) begin
					// requeue the running thread as resumable
					will_push   = 1'b1;
					q_push_data = {1'b0, {ADDR_W{1'b0}}, cur_q};
				end
			end
			REQ_FINISH: begin
				is_dispatch = 1'b1;
				if (cur_q != '0) occ_d[cur_q] = 1'b0;
			end
			REQ_NONE: begin
				res.thread_id      = TID_W'(cur_q);
				res.running_thread = TID_W'(cur_q);
			end
			default: ;
		endcase

		// An empty queue hands back the thread pushed in this same cycle.
		pop_ok   = (q_count != '0) || (will_push && (q_count < CNT_W'(MAX_THREADS)));
		pop_data = (q_count == '0) ? q_push_data : q_head;
		pop_slot = pop_data[SLOT_W-1:0];

		if (is_dispatch) begin
			if (pop_ok) begin
				cur_d           = pop_slot;
				res.fresh_start = pop_data[QD_W-1];
				res.start_addr  = pop_data[QD_W-1] ? pop_data[QD_W-2 -: ADDR_W] : '0;
			end else begin
				cur_d = '0;
			end
			res.thread_id      = TID_W'(cur_d);
			res.running_thread = TID_W'(cur_d);
		end

		q_ctl.push = exec_fire && will_push;
		q_ctl.pop  = exec_fire && is_dispatch;
	end

	tsrr_ready_queue #(
		.DEPTH  (MAX_THREADS),
		.DATA_W (QD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.push_data (q_push_data),
		.head_data (q_head),
		.count     (q_count)
	);

	// Hold the accepted request for the execute state.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q   <= in_data.req_type;
			entry_q <= in_data.entry_addr;
		end
	end

	// Sequencer state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_fire) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Slot occupancy, running thread and slot count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			cur_q   <= '0;
			slots_q <= SLOTS_RESET;
		end else begin
			if (cfg_we) slots_q <= cfg_wdata;
			if (exec_fire) begin
				occ_q <= occ_d;
				cur_q <= cur_d;
			end
		end
	end

	// A running non-main thread always owns an occupied slot.
	`TSRR_ASSERT(a_cur_occupied, clk, arst_n, (cur_q == '0) || occ_q[cur_q])
	// The queue never holds more entries than there are occupied slots.
	`TSRR_ASSERT(a_queue_bound, clk, arst_n, 32'(q_count) <= 32'($countones(occ_q)))
	// A dispatch only hands out occupied slots, and the result shows it next cycle.
	`TSRR_ASSERT_NEXT(a_dispatch_occ, clk, arst_n, exec_fire && is_dispatch && pop_ok,
		occ_q[cur_q] && out_valid_q && (out_data_q.running_thread == TID_W'(cur_q)))

endmodule
